### design/ventilation_fan_state_machine_unit_macros.svh
// assertion macros shared by the fan controller modules
// no dependencies; included by the files that carry assertions
`ifndef VENTILATION_FAN_STATE_MACHINE_UNIT_MACROS_SVH
`define VENTILATION_FAN_STATE_MACHINE_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define VFSM_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VFSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/vfsm_pkg.sv
// shared types, widths and codes of the ventilation fan controller
// no dependencies; imported by every module of the block
package vfsm_pkg;

    localparam int TIME_W     = 32;
    localparam int HUM_W      = 14;
    localparam int VOC_W      = 13;
    localparam int STAGE_W    = 2;
    localparam int MODE_W     = 2;
    localparam int SECONDS_W  = 16;
    localparam int MAX_OFF_W  = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [HUM_W-1:0] HUM_MAX        = 14'd10000;
    localparam logic [VOC_W-1:0] VOC_MAX        = 13'd5000;
    localparam logic [HUM_W-1:0] HUM_FAIL_VALUE = 14'd10000;
    localparam logic [VOC_W-1:0] VOC_FAIL_VALUE = 13'd5000;

    // fan speed codes
    localparam logic [STAGE_W-1:0] STAGE_OFF  = 2'd0;
    localparam logic [STAGE_W-1:0] STAGE_LOW  = 2'd1;
    localparam logic [STAGE_W-1:0] STAGE_MID  = 2'd2;
    localparam logic [STAGE_W-1:0] STAGE_FULL = 2'd3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HUM_LIMIT,
        REG_VOC_LIMIT,
        REG_HUM_CHANGE,
        REG_VOC_CHANGE,
        REG_CHECK_INTERVAL,
        REG_AFTERRUN,
        REG_MAX_OFF,
        REG_FLUSH
    } t_reg_idx;

    typedef struct packed {
        logic [HUM_W-1:0]     humidity_limit;
        logic [VOC_W-1:0]     voc_limit;
        logic [HUM_W-1:0]     humidity_change_limit;
        logic [VOC_W-1:0]     voc_change_limit;
        logic [SECONDS_W-1:0] check_interval_s;
        logic [SECONDS_W-1:0] afterrun_s;
        logic [MAX_OFF_W-1:0] max_off_s;
        logic [SECONDS_W-1:0] flush_s;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_seconds;
        logic [HUM_W-1:0]  humidity_reading;
        logic              humidity_valid;
        logic [VOC_W-1:0]  voc_reading;
        logic              voc_valid;
        logic              presence;
    } t_tick;

    typedef struct packed {
        logic [STAGE_W-1:0] fan_stage;
        logic [MODE_W-1:0]  mode;
        logic               humidity_good;
        logic               voc_ok;
        logic [HUM_W-1:0]   humidity_applied;
        logic [VOC_W-1:0]   voc_applied;
        logic [HUM_W-1:0]   humidity_reference;
        logic [VOC_W-1:0]   voc_reference;
        logic [TIME_W-1:0]  age_since_check;
        logic [TIME_W-1:0]  age_since_on;
        logic [TIME_W-1:0]  age_since_afterrun;
        logic [TIME_W-1:0]  age_since_flush;
    } t_result;

endpackage

### design/vfsm_cfg.sv
// configuration register file of the fan controller
// depends on vfsm_pkg
module vfsm_cfg (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vfsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfsm_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output vfsm_pkg::t_cfg                  o_cfg
);
    import vfsm_pkg::*;

    t_cfg r_cfg;

    // the user must issue writes only while idle; the block does not check it. every request is taken at once
    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.humidity_limit        <= HUM_W'(7000);
            r_cfg.voc_limit             <= VOC_W'(1500);
            r_cfg.humidity_change_limit <= HUM_W'(100);
            r_cfg.voc_change_limit      <= VOC_W'(100);
            r_cfg.check_interval_s      <= SECONDS_W'(300);
            r_cfg.afterrun_s            <= SECONDS_W'(300);
            r_cfg.max_off_s             <= MAX_OFF_W'(86400);
            r_cfg.flush_s               <= SECONDS_W'(60);
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_HUM_LIMIT:      r_cfg.humidity_limit        <= i_cfg_data[HUM_W-1:0];
                REG_VOC_LIMIT:      r_cfg.voc_limit             <= i_cfg_data[VOC_W-1:0];
                REG_HUM_CHANGE:     r_cfg.humidity_change_limit <= i_cfg_data[HUM_W-1:0];
                REG_VOC_CHANGE:     r_cfg.voc_change_limit      <= i_cfg_data[VOC_W-1:0];
                REG_CHECK_INTERVAL: r_cfg.check_interval_s      <= i_cfg_data[SECONDS_W-1:0];
                REG_AFTERRUN:       r_cfg.afterrun_s            <= i_cfg_data[SECONDS_W-1:0];
                REG_MAX_OFF:        r_cfg.max_off_s             <= i_cfg_data[MAX_OFF_W-1:0];
                REG_FLUSH:          r_cfg.flush_s               <= i_cfg_data[SECONDS_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

### design/vfsm_in_stage.sv
// input register for one tick request
// depends on vfsm_pkg
module vfsm_in_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  vfsm_pkg::t_tick i_tick,
    input  logic            i_advance,
    output logic            o_valid,
    output vfsm_pkg::t_tick o_tick
);
    import vfsm_pkg::*;

    logic  r_valid;
    t_tick r_tick;

    // free slot, or the held request moves on this cycle
    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_tick  = r_tick;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_tick <= i_tick;
        end
    end

endmodule

### design/vfsm_fsm.sv
// fan state machine: decision logic, controller state and result register
// depends on vfsm_pkg and the assertion macro header
`include "ventilation_fan_state_machine_unit_macros.svh"
module vfsm_fsm (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  vfsm_pkg::t_cfg    i_cfg,
    input  logic              i_in_valid,
    input  vfsm_pkg::t_tick   i_tick,
    output logic              o_advance,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output vfsm_pkg::t_result o_result
);
    import vfsm_pkg::*;

    typedef enum logic [MODE_W-1:0] {
        M_OFF,
        M_FLUSH,
        M_SNIFF,
        M_RUN
    } t_mode;

    t_mode             r_mode;
    logic              r_started;
    logic [HUM_W-1:0]  r_hum_stored;
    logic [VOC_W-1:0]  r_voc_stored;
    logic [TIME_W-1:0] r_check_time;
    logic [TIME_W-1:0] r_on_time;
    logic [TIME_W-1:0] r_afterrun_time;
    logic [TIME_W-1:0] r_flush_stamp;
    logic              r_out_valid;
    t_result           r_out;

    t_mode              n_mode;
    logic [STAGE_W-1:0] n_stage;
    logic [HUM_W-1:0]   n_hum_stored;
    logic [VOC_W-1:0]   n_voc_stored;
    logic [TIME_W-1:0]  n_check_time;
    logic [TIME_W-1:0]  n_on_time;
    logic [TIME_W-1:0]  n_afterrun_time;
    logic [TIME_W-1:0]  n_flush_stamp;
    t_result            n_out;

    logic [TIME_W-1:0]  dt_check;
    logic [TIME_W-1:0]  dt_on;
    logic [TIME_W-1:0]  dt_afterrun;
    logic [TIME_W-1:0]  dt_flush;
    logic [HUM_W-1:0]   hum_sat;
    logic [VOC_W-1:0]   voc_sat;
    logic [HUM_W-1:0]   hum_applied;
    logic [VOC_W-1:0]   voc_applied;
    logic [HUM_W-1:0]   hum_diff;
    logic [VOC_W-1:0]   voc_diff;
    logic               above;
    logic               moved;
    logic               check_due;
    logic               on_over;
    logic               afterrun_over;
    logic               flush_over;
    logic [STAGE_W-1:0] run_stage;
    logic               do_run;
    logic               do_sniff_decide;
    logic               set_check;
    logic               set_afterrun;
    logic               set_flush;

    assign o_advance   = i_in_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_comb begin
        // elapsed times; the first tick sees every timestamp at now
        dt_check    = r_started ? i_tick.now_seconds - r_check_time    : '0;
        dt_on       = r_started ? i_tick.now_seconds - r_on_time       : '0;
        dt_afterrun = r_started ? i_tick.now_seconds - r_afterrun_time : '0;
        dt_flush    = r_started ? i_tick.now_seconds - r_flush_stamp   : '0;

        hum_sat  = (i_tick.humidity_reading > HUM_MAX) ? HUM_MAX : i_tick.humidity_reading;
        voc_sat  = (i_tick.voc_reading > VOC_MAX) ? VOC_MAX : i_tick.voc_reading;
        hum_applied = i_tick.humidity_valid ? hum_sat : HUM_FAIL_VALUE;
        voc_applied = i_tick.voc_valid ? voc_sat : VOC_FAIL_VALUE;

        above = (hum_applied > i_cfg.humidity_limit) || (voc_applied > i_cfg.voc_limit);

        hum_diff = (hum_applied > r_hum_stored) ? hum_applied - r_hum_stored
                                                : r_hum_stored - hum_applied;
        voc_diff = (voc_applied > r_voc_stored) ? voc_applied - r_voc_stored
                                                : r_voc_stored - voc_applied;
        moved    = (hum_diff > i_cfg.humidity_change_limit) ||
                   (voc_diff > i_cfg.voc_change_limit);

        check_due     = dt_check    > TIME_W'(i_cfg.check_interval_s);
        on_over       = dt_on       > TIME_W'(i_cfg.max_off_s);
        afterrun_over = dt_afterrun > TIME_W'(i_cfg.afterrun_s);
        flush_over    = dt_flush    > TIME_W'(i_cfg.flush_s);

        run_stage = i_tick.presence ? STAGE_MID : STAGE_FULL;

        n_mode          = r_mode;
        n_stage         = STAGE_OFF;
        do_run          = 1'b0;
        do_sniff_decide = 1'b0;
        set_check       = 1'b0;
        set_afterrun    = 1'b0;
        set_flush       = 1'b0;

        case (r_mode)
            M_RUN: begin
                if (!check_due) begin
                    n_stage = run_stage;
                end else if (moved) begin
                    do_run = 1'b1;
                end else if (i_tick.presence) begin
                    do_sniff_decide = 1'b1;
                end else begin
                    n_mode = M_OFF;
                end
            end
            M_OFF: begin
                if (i_tick.presence || on_over) begin
                    n_mode    = M_FLUSH;
                    n_stage   = STAGE_LOW;
                    set_flush = 1'b1;
                end
            end
            M_SNIFF: begin
                do_sniff_decide = 1'b1;
            end
            M_FLUSH: begin
                n_stage = STAGE_LOW;
                if (flush_over) begin
                    n_mode = M_SNIFF;
                end
            end
            default: begin
                n_mode = M_OFF;
            end
        endcase

        if (do_sniff_decide) begin
            if (above) begin
                do_run = 1'b1;
            end else if (i_tick.presence) begin
                n_mode       = M_SNIFF;
                n_stage      = STAGE_LOW;
                set_afterrun = 1'b1;
            end else if (afterrun_over) begin
                n_mode  = M_OFF;
                n_stage = STAGE_OFF;
            end else begin
                n_mode  = M_SNIFF;
                n_stage = STAGE_LOW;
            end
        end

        // run entry takes fresh references and restarts the check interval
        if (do_run) begin
            n_mode    = M_RUN;
            n_stage   = run_stage;
            set_check = 1'b1;
        end

        n_hum_stored    = do_run ? hum_applied : r_hum_stored;
        n_voc_stored    = do_run ? voc_applied : r_voc_stored;
        n_check_time    = (set_check || !r_started) ? i_tick.now_seconds : r_check_time;
        n_on_time       = ((n_stage != STAGE_OFF) || !r_started) ? i_tick.now_seconds
                                                                   : r_on_time;
        n_afterrun_time = (set_afterrun || !r_started) ? i_tick.now_seconds
                                                       : r_afterrun_time;
        n_flush_stamp   = (set_flush || !r_started) ? i_tick.now_seconds : r_flush_stamp;

        n_out.fan_stage          = n_stage;
        n_out.mode               = MODE_W'(n_mode);
        n_out.humidity_good      = i_tick.humidity_valid;
        n_out.voc_ok             = i_tick.voc_valid;
        n_out.humidity_applied   = hum_applied;
        n_out.voc_applied        = voc_applied;
        n_out.humidity_reference = n_hum_stored;
        n_out.voc_reference      = n_voc_stored;
        // a timestamp set this tick reads back as zero age
        n_out.age_since_check    = set_check ? '0 : dt_check;
        n_out.age_since_on       = (n_stage != STAGE_OFF) ? '0 : dt_on;
        n_out.age_since_afterrun = set_afterrun ? '0 : dt_afterrun;
        n_out.age_since_flush    = set_flush ? '0 : dt_flush;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= M_OFF;
            r_started       <= 1'b0;
            r_hum_stored    <= '0;
            r_voc_stored    <= '0;
            r_check_time    <= '0;
            r_on_time       <= '0;
            r_afterrun_time <= '0;
            r_flush_stamp   <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            if (o_advance) begin
                r_mode          <= n_mode;
                r_started       <= 1'b1;
                r_hum_stored    <= n_hum_stored;
                r_voc_stored    <= n_voc_stored;
                r_check_time    <= n_check_time;
                r_on_time       <= n_on_time;
                r_afterrun_time <= n_afterrun_time;
                r_flush_stamp   <= n_flush_stamp;
                r_out           <= n_out;
                r_out_valid     <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid     <= 1'b0;
            end
        end
    end

    `VFSM_ASSERT_NEXT(a_advance_fills_out, i_clk, i_rst_n, o_advance, r_out_valid, "processed request did not reach the result register")
    `VFSM_ASSERT_NOW(a_off_matches_stage, i_clk, i_rst_n, r_out_valid, ((r_out.fan_stage == STAGE_OFF) == (r_out.mode == MODE_W'(M_OFF))), "fan stage off disagrees with mode off")
    `VFSM_ASSERT_NOW(a_run_stage, i_clk, i_rst_n, r_out_valid && (r_out.mode == MODE_W'(M_RUN)), ((r_out.fan_stage == STAGE_MID) || (r_out.fan_stage == STAGE_FULL)), "run mode without mid or full speed")
    `VFSM_ASSERT_NOW(a_on_age_zero, i_clk, i_rst_n, r_out_valid && (r_out.fan_stage != STAGE_OFF), (r_out.age_since_on == '0), "running fan reports nonzero age since on")
    `VFSM_ASSERT_NEXT(a_mode_matches_state, i_clk, i_rst_n, o_advance, (r_out.mode == MODE_W'(r_mode)), "reported mode differs from stored state")

endmodule

### design/ventilation_fan_state_machine_unit.sv
// top level of the bathroom ventilation fan controller
// depends on vfsm_pkg, vfsm_cfg, vfsm_in_stage and vfsm_fsm
//
// Bathroom fan controller. Each tick request carries the time in seconds, a
// humidity reading (0.01 %RH), a VOC reading (0.1 index units) with valid
// flags, and a presence flag (light on). Invalid readings are replaced by
// fail-safe maxima, readings above range saturate. The controller walks off,
// flush, sniff and run and returns one result per tick: fan stage (off, low,
// mid with presence, full without), the mode after the tick, the values used,
// the run references and the ages of its four timestamps (wrapping 32 bit).
// A tick passes through an input register, one level of compare logic and a
// result register, where the result is held until it is taken, and a new
// tick can be accepted every cycle as long as results are taken. The state
// update for one tick settles in that single compare stage, which sets the
// rate. Configuration writes are taken at once (ready is always high) and
// must only be issued while no tick is in flight.
module ventilation_fan_state_machine_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tick request channel
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [vfsm_pkg::TIME_W-1:0]     i_now_seconds,
    input  logic [vfsm_pkg::HUM_W-1:0]      i_humidity_reading,
    input  logic                           i_humidity_valid,
    input  logic [vfsm_pkg::VOC_W-1:0]      i_voc_reading,
    input  logic                           i_voc_valid,
    input  logic                           i_presence,
    // result channel
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [vfsm_pkg::STAGE_W-1:0]    o_fan_stage,
    output logic [vfsm_pkg::MODE_W-1:0]     o_mode,
    output logic                           o_humidity_good,
    output logic                           o_voc_ok,
    output logic [vfsm_pkg::HUM_W-1:0]      o_humidity_applied,
    output logic [vfsm_pkg::VOC_W-1:0]      o_voc_applied,
    output logic [vfsm_pkg::HUM_W-1:0]      o_humidity_reference,
    output logic [vfsm_pkg::VOC_W-1:0]      o_voc_reference,
    output logic [vfsm_pkg::TIME_W-1:0]     o_age_since_check,
    output logic [vfsm_pkg::TIME_W-1:0]     o_age_since_on,
    output logic [vfsm_pkg::TIME_W-1:0]     o_age_since_afterrun,
    output logic [vfsm_pkg::TIME_W-1:0]     o_age_since_flush,
    // configuration write channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [vfsm_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [vfsm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import vfsm_pkg::*;

    t_cfg    cfg;
    t_tick   in_tick;
    t_tick   held_tick;
    t_result result;
    logic    held_valid;
    logic    advance;

    // pack the request fields
    assign in_tick.now_seconds      = i_now_seconds;
    assign in_tick.humidity_reading = i_humidity_reading;
    assign in_tick.humidity_valid   = i_humidity_valid;
    assign in_tick.voc_reading      = i_voc_reading;
    assign in_tick.voc_valid        = i_voc_valid;
    assign in_tick.presence         = i_presence;

    // register file for the eight limits and timers
    vfsm_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // input register, refilled in the cycle its request moves on
    vfsm_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_ready   (o_in_ready),
        .i_tick    (in_tick),
        .i_advance (advance),
        .o_valid   (held_valid),
        .o_tick    (held_tick)
    );

    // decision logic, controller state and result register
    vfsm_fsm u_fsm (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_in_valid  (held_valid),
        .i_tick      (held_tick),
        .o_advance   (advance),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_result    (result)
    );

    // unpack the result fields
    assign o_fan_stage          = result.fan_stage;
    assign o_mode               = result.mode;
    assign o_humidity_good      = result.humidity_good;
    assign o_voc_ok             = result.voc_ok;
    assign o_humidity_applied   = result.humidity_applied;
    assign o_voc_applied        = result.voc_applied;
    assign o_humidity_reference = result.humidity_reference;
    assign o_voc_reference      = result.voc_reference;
    assign o_age_since_check    = result.age_since_check;
    assign o_age_since_on       = result.age_since_on;
    assign o_age_since_afterrun = result.age_since_afterrun;
    assign o_age_since_flush    = result.age_since_flush;

endmodule
